@@ sv/fplmi_pkg.sv @@
// ----------------------------------------------------------------------------
// fplmi_pkg
// Shared types, constants and the control store of the page map inserter.
// ----------------------------------------------------------------------------
package fplmi_pkg;

    localparam int TABLE_PAGES_DEF = 64;

    localparam int ENTRY_W = 64;
    localparam int IDX_W   = 9;
    localparam int FRAME_W = 40;
    localparam int VPAGE_W = 36;
    localparam int FLAGS_W = 12;
    localparam int LEAF_W  = 52;

    localparam logic [FLAGS_W-1:0] LINK_FLAGS = 12'h007;

    localparam logic [1:0] LEVEL_LAST_UPPER = 2'd2;
    localparam logic [1:0] LEVEL_LEAF       = 2'd3;

    typedef struct packed {
        logic [VPAGE_W-1:0] virtual_page;
        logic [FRAME_W-1:0] physical_frame;
        logic [FLAGS_W-1:0] page_flags;
    } map_req_t;

    typedef struct packed {
        logic              status;
        logic [1:0]        tables_created;
        logic [LEAF_W-1:0] leaf_entry;
    } map_rsp_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_READ,
        OP_DESCEND,
        OP_LINK,
        OP_LEAF,
        OP_FAIL
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_ABSENT,
        COND_STRAY,
        COND_MORE_LEVELS,
        COND_FULL,
        COND_LEVELS_DONE
    } cond_t;

    typedef logic [3:0] upc_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    // Datapath status seen by the sequencer's jump logic
    typedef struct packed {
        logic no_start;
        logic absent;
        logic stray;
        logic more_levels;
        logic full;
        logic levels_done;
    } cond_flags_t;

    localparam upc_t ST_IDLE    = 4'd0;
    localparam upc_t ST_READ    = 4'd1;
    localparam upc_t ST_TEST    = 4'd2;
    localparam upc_t ST_CHKPTR  = 4'd3;
    localparam upc_t ST_DESCEND = 4'd4;
    localparam upc_t ST_ROOM    = 4'd5;
    localparam upc_t ST_LOOP    = 4'd6;
    localparam upc_t ST_LINK    = 4'd7;
    localparam upc_t ST_LEAF    = 4'd8;
    localparam upc_t ST_FAIL    = 4'd9;

    // Jump to target when the condition holds, else fall through to the next step.
    function automatic ucode_t ucode_rom(upc_t pc);
        ucode_t w;
        case (pc)
            ST_IDLE:    w = '{op: OP_NOP,     cond: COND_NO_START,    target: ST_IDLE};
            ST_READ:    w = '{op: OP_READ,    cond: COND_NEVER,       target: ST_IDLE};
            ST_TEST:    w = '{op: OP_NOP,     cond: COND_ABSENT,      target: ST_ROOM};
            ST_CHKPTR:  w = '{op: OP_NOP,     cond: COND_STRAY,       target: ST_FAIL};
            ST_DESCEND: w = '{op: OP_DESCEND, cond: COND_MORE_LEVELS, target: ST_READ};
            ST_ROOM:    w = '{op: OP_NOP,     cond: COND_FULL,        target: ST_FAIL};
            ST_LOOP:    w = '{op: OP_NOP,     cond: COND_LEVELS_DONE, target: ST_LEAF};
            ST_LINK:    w = '{op: OP_LINK,    cond: COND_ALWAYS,      target: ST_LOOP};
            ST_LEAF:    w = '{op: OP_LEAF,    cond: COND_ALWAYS,      target: ST_IDLE};
            ST_FAIL:    w = '{op: OP_FAIL,    cond: COND_ALWAYS,      target: ST_IDLE};
            default:    w = '{op: OP_NOP,     cond: COND_ALWAYS,      target: ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [IDX_W-1:0] walk_index(logic [VPAGE_W-1:0] vp, logic [1:0] lvl);
        logic [IDX_W-1:0] r;
        case (lvl)
            2'd0:    r = vp[35:27];
            2'd1:    r = vp[26:18];
            2'd2:    r = vp[17:9];
            default: r = vp[8:0];
        endcase
        return r;
    endfunction

endpackage

@@ sv/fplmi_ram.sv @@
// ----------------------------------------------------------------------------
// fplmi_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fplmi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/fplmi_seq.sv @@
// ----------------------------------------------------------------------------
// fplmi_seq
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// ----------------------------------------------------------------------------
module fplmi_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fplmi_pkg::cond_flags_t flags,
    output fplmi_pkg::ucode_t      ctl,
    output logic                   idle
);

    fplmi_pkg::upc_t pc_reg;
    fplmi_pkg::upc_t pc_next;
    logic            take;

    assign ctl  = fplmi_pkg::ucode_rom(pc_reg);
    assign idle = (pc_reg == fplmi_pkg::ST_IDLE);

    always_comb
    begin
        case (ctl.cond)
            fplmi_pkg::COND_NEVER:       take = 1'b0;
            fplmi_pkg::COND_ALWAYS:      take = 1'b1;
            fplmi_pkg::COND_NO_START:    take = flags.no_start;
            fplmi_pkg::COND_ABSENT:      take = flags.absent;
            fplmi_pkg::COND_STRAY:       take = flags.stray;
            fplmi_pkg::COND_MORE_LEVELS: take = flags.more_levels;
            fplmi_pkg::COND_FULL:        take = flags.full;
            fplmi_pkg::COND_LEVELS_DONE: take = flags.levels_done;
            default:                     take = 1'b1;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            pc_next = ctl.target;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= fplmi_pkg::ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Leave idle only on a transfer
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (idle && flags.no_start) |=> (pc_reg == fplmi_pkg::ST_IDLE))
        else $error("sequencer left idle without a transfer");

endmodule

@@ sv/fplmi_dp.sv @@
// ----------------------------------------------------------------------------
// fplmi_dp
// Walk datapath: request, page, level and allocator registers, table memory
// port control, clearing sweep after reset, and the result register.
// ----------------------------------------------------------------------------
module fplmi_dp #(
    parameter int TABLE_PAGES = fplmi_pkg::TABLE_PAGES_DEF,
    parameter int ADDR_W      = $clog2(TABLE_PAGES * 512)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  fplmi_pkg::map_req_t               req,
    input  logic                              cfg_we,
    input  logic [fplmi_pkg::FRAME_W-1:0]     cfg_data,
    input  fplmi_pkg::ucode_t                 ctl,
    input  logic                              seq_idle,
    output fplmi_pkg::cond_flags_t            flags,
    output logic                              busy,
    output logic                              done,
    output fplmi_pkg::map_rsp_t               rsp,
    output logic                              ram_we,
    output logic                              ram_re,
    output logic [ADDR_W-1:0]                 ram_addr,
    output logic [fplmi_pkg::ENTRY_W-1:0]     ram_wdata,
    input  logic [fplmi_pkg::ENTRY_W-1:0]     ram_rdata
);

    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int NF_W   = $clog2(TABLE_PAGES + 1);
    localparam int NS_W   = NF_W + 1;
    localparam int FW     = fplmi_pkg::FRAME_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_PAGES * 512 - 1);

    fplmi_pkg::map_req_t          req_reg;
    logic [PAGE_W-1:0]            page_reg,      page_next;
    logic [1:0]                   level_reg,     level_next;
    logic [1:0]                   created_reg,   created_next;
    logic [NF_W-1:0]              next_free_reg, next_free_next;
    logic [FW-1:0]                base_reg;
    logic                         clearing_reg;
    logic [ADDR_W-1:0]            clear_addr_reg;
    logic                         done_reg,      done_next;
    fplmi_pkg::map_rsp_t          rsp_reg,       rsp_next;

    logic                         accept;
    logic [FW-1:0]                ptr_page;
    logic [FW-1:0]                link_frame;
    logic [NS_W-1:0]              need_sum;
    logic [fplmi_pkg::IDX_W-1:0]  cur_idx;
    logic [fplmi_pkg::IDX_W-1:0]  leaf_idx;

    assign busy   = !seq_idle || clearing_reg;
    assign accept = start && !busy;

    assign ptr_page   = ram_rdata[51:12] - base_reg;
    assign link_frame = base_reg + FW'(next_free_reg);
    assign need_sum   = NS_W'(next_free_reg) + NS_W'(fplmi_pkg::LEVEL_LEAF - level_reg);
    assign cur_idx    = fplmi_pkg::walk_index(req_reg.virtual_page, level_reg);
    assign leaf_idx   = fplmi_pkg::walk_index(req_reg.virtual_page, fplmi_pkg::LEVEL_LEAF);

    always_comb
    begin
        flags.no_start    = !accept;
        flags.absent      = !ram_rdata[0];
        flags.stray       = (ptr_page >= FW'(next_free_reg));
        flags.more_levels = (level_reg < fplmi_pkg::LEVEL_LAST_UPPER);
        flags.full        = (need_sum > NS_W'(TABLE_PAGES));
        flags.levels_done = (level_reg == fplmi_pkg::LEVEL_LEAF);
    end

    always_comb
    begin
        page_next      = page_reg;
        level_next     = level_reg;
        created_next   = created_reg;
        next_free_next = next_free_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = {page_reg, cur_idx};
        ram_wdata      = '0;
        if (clearing_reg)
        begin
            ram_we   = 1'b1;
            ram_addr = clear_addr_reg;
        end
        else if (accept)
        begin
            page_next    = '0;
            level_next   = '0;
            created_next = '0;
        end
        else
        begin
            case (ctl.op)
                fplmi_pkg::OP_READ:
                begin
                    ram_re = 1'b1;
                end
                fplmi_pkg::OP_DESCEND:
                begin
                    page_next  = ptr_page[PAGE_W-1:0];
                    level_next = level_reg + 2'd1;
                end
                fplmi_pkg::OP_LINK:
                begin
                    // Point the missing entry at a fresh, already zero page
                    ram_we         = 1'b1;
                    ram_wdata      = {12'b0, link_frame, fplmi_pkg::LINK_FLAGS};
                    page_next      = next_free_reg[PAGE_W-1:0];
                    next_free_next = next_free_reg + NF_W'(1);
                    level_next     = level_reg + 2'd1;
                    created_next   = created_reg + 2'd1;
                end
                fplmi_pkg::OP_LEAF:
                begin
                    ram_we    = 1'b1;
                    ram_addr  = {page_reg, leaf_idx};
                    ram_wdata = {12'b0, req_reg.physical_frame, req_reg.page_flags};
                    done_next = 1'b1;
                    rsp_next.status         = 1'b0;
                    rsp_next.tables_created = created_reg;
                    rsp_next.leaf_entry     = {req_reg.physical_frame, req_reg.page_flags};
                end
                fplmi_pkg::OP_FAIL:
                begin
                    done_next = 1'b1;
                    rsp_next.status         = 1'b1;
                    rsp_next.tables_created = '0;
                    rsp_next.leaf_entry     = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg       <= '0;
            level_reg      <= '0;
            created_reg    <= '0;
            next_free_reg  <= NF_W'(1);
            base_reg       <= '0;
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            page_reg      <= page_next;
            level_reg     <= level_next;
            created_reg   <= created_next;
            next_free_reg <= next_free_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                base_reg <= cfg_data;
            end
            if (clearing_reg)
            begin
                clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
                if (clear_addr_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_link_room: assert property (@(posedge clk) disable iff (!rst_n)
        (!clearing_reg && ctl.op == fplmi_pkg::OP_LINK) |-> (next_free_reg < NF_W'(TABLE_PAGES)))
        else $error("table page allocated beyond the table memory");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (!clearing_reg && (ctl.op == fplmi_pkg::OP_DESCEND || ctl.op == fplmi_pkg::OP_LINK))
        |-> (level_reg != fplmi_pkg::LEVEL_LEAF))
        else $error("walk advanced past the leaf level");

    a_walk_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (level_reg == 2'd0 && page_reg == '0 && created_reg == 2'd0))
        else $error("walk did not restart at the root");

endmodule

@@ sv/four_level_page_map_inserter_top.sv @@
// ----------------------------------------------------------------------------
// four_level_page_map_inserter_top
// Inserts virtual page to frame mappings into four-level page tables held in
// an internal table memory, allocating intermediate tables on demand.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the transfer happens on a
//   clock edge with start high and busy low. busy stays high until the
//   result of that request has been issued.
//   Result channel: done pulses for one cycle with rsp valid; the receiver
//   must take it then, there is no way to hold it off.
//   Configuration: cfg_we with cfg_data writes the base frame of table page 0.
//   Write it only while the block is idle.
// Timing: one table memory port serves every step, one microcode step per
//   cycle. busy drops with done, so a new request is taken only once the
//   last one is done. A full walk costs a read, two test steps and a
//   descend step per upper level, then a room check, a loop check and the
//   leaf write; each new table costs one link step plus a loop check.
// Reset: the table memory is swept to zero, one entry per cycle, over all
//   TABLE_PAGES*512 entries (32768 at the default); busy stays high meanwhile.
//   The allocator restarts at page 1 and the base frame at 0.
// ----------------------------------------------------------------------------
module four_level_page_map_inserter_top #(
    parameter int TABLE_PAGES = fplmi_pkg::TABLE_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  fplmi_pkg::map_req_t           req,
    output logic                          done,
    output fplmi_pkg::map_rsp_t           rsp,
    input  logic                          cfg_we,
    input  logic [fplmi_pkg::FRAME_W-1:0] cfg_data
);

    localparam int DEPTH  = TABLE_PAGES * 512;
    localparam int ADDR_W = $clog2(DEPTH);

    fplmi_pkg::ucode_t             ctl;
    fplmi_pkg::cond_flags_t        flags;
    logic                          seq_idle;
    logic                          ram_we;
    logic                          ram_re;
    logic [ADDR_W-1:0]             ram_addr;
    logic [fplmi_pkg::ENTRY_W-1:0] ram_wdata;
    logic [fplmi_pkg::ENTRY_W-1:0] ram_rdata;

    fplmi_ram #(
        .WIDTH (fplmi_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table_mem (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    fplmi_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl),
        .idle  (seq_idle)
    );

    fplmi_dp #(
        .TABLE_PAGES (TABLE_PAGES),
        .ADDR_W      (ADDR_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .seq_idle  (seq_idle),
        .flags     (flags),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

endmodule
